// ===== rtl/b64se_pkg.sv =====
// b64se_pkg: shared types, constants and the digit-to-ASCII function for the
// streaming base64 encoder. No dependencies.
`default_nettype none

package b64se_pkg;

    localparam int JOB_CHARS = 4;                       // most characters one byte causes
    localparam int JOB_IDX_W = $clog2(JOB_CHARS);
    localparam int JOB_DEPTH = 4;                       // entries in the job queue
    localparam int QPTR_W    = $clog2(JOB_DEPTH);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam logic [5:0] DIG_LOWER = 6'd26;
    localparam logic [5:0] DIG_NUM   = 6'd52;
    localparam logic [5:0] DIG_PLUS  = 6'd62;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_run;
        logic       end_of_message;
    } t_out_beat;

    // One classified byte: the characters it causes, ready to stream out.
    typedef struct packed {
        logic [JOB_CHARS-1:0][7:0] chars;
        logic [JOB_IDX_W-1:0]      last_idx;
        logic                      fin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < DIG_LOWER) begin
            r = CH_UPPER_A + {2'b00, v};
        end else if (v < DIG_NUM) begin
            r = CH_LOWER_A + {2'b00, v - DIG_LOWER};
        end else if (v < DIG_PLUS) begin
            r = CH_ZERO + {2'b00, v - DIG_NUM};
        end else if (v == DIG_PLUS) begin
            r = CH_PLUS;
        end else begin
            r = CH_SLASH;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/b64se_front.sv =====
// b64se_front: accepts raw bytes, tracks the 3-byte group phase and leftover
// bits, and turns each byte into a job of characters. Uses b64se_pkg.
`default_nettype none

module b64se_front
    import b64se_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    input  wire t_q_status i_q_status,
    output logic           o_push,
    output t_job           o_job
);

    typedef enum logic [1:0] {
        PH_0,
        PH_1,
        PH_2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [5:0] r_left,  n_left;
    logic [7:0] b;
    logic       fin;

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && o_in_ready;
    assign b          = i_in_beat.data_byte;
    assign fin        = i_in_beat.is_final;

    always_comb begin
        o_job.chars    = {JOB_CHARS{CH_PAD}};
        o_job.fin      = fin;
        o_job.last_idx = '0;
        n_phase        = r_phase;
        n_left         = r_left;
        unique case (r_phase)
            PH_1: begin
                n_left         = {b[3:0], 2'b00};
                n_phase        = PH_2;
                o_job.chars[0] = b64_char(r_left | {2'b00, b[7:4]});
                o_job.chars[1] = b64_char({b[3:0], 2'b00});
                o_job.last_idx = fin ? JOB_IDX_W'(2) : JOB_IDX_W'(0);
            end
            PH_2: begin
                n_left         = '0;
                n_phase        = PH_0;
                o_job.chars[0] = b64_char(r_left | {4'b0000, b[7:6]});
                o_job.chars[1] = b64_char(b[5:0]);
                o_job.last_idx = JOB_IDX_W'(1);
            end
            default: begin
                // a phase code that cannot arise acts as phase zero
                n_left         = {b[1:0], 4'b0000};
                n_phase        = PH_1;
                o_job.chars[0] = b64_char(b[7:2]);
                o_job.chars[1] = b64_char({b[1:0], 4'b0000});
                o_job.last_idx = fin ? JOB_IDX_W'(3) : JOB_IDX_W'(0);
            end
        endcase
        if (fin) begin
            n_phase = PH_0;
            n_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64se_queue.sv =====
// b64se_queue: short job queue between front and back, flip-flop storage.
// Uses b64se_pkg.
`default_nettype none

module b64se_queue
    import b64se_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    t_job              r_mem [JOB_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_job           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == (QPTR_W+1)'(JOB_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/b64se_back.sv =====
// b64se_back: streams the queued jobs out one character per beat through an
// output register. Uses b64se_pkg.
`default_nettype none

module b64se_back
    import b64se_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job      i_job,
    input  wire t_q_status i_q_status,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    logic                 r_valid;
    t_out_beat            r_beat, n_beat;
    logic [JOB_IDX_W-1:0] r_idx;
    logic                 load, take, last;

    assign load = !r_valid || i_out_ready;
    assign take = load && !i_q_status.empty;
    assign last = (r_idx == i_job.last_idx);
    assign o_pop = take && last;

    always_comb begin
        n_beat.out_char       = i_job.chars[r_idx];
        n_beat.end_of_run     = last;
        n_beat.end_of_message = last && i_job.fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= take;
            if (take) begin
                r_idx <= last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_beat <= n_beat;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

endmodule

`default_nettype wire

// ===== rtl/base64_stream_encoder_unit.sv =====
// A byte's job enters the job queue, then its first character loads the output register.
// Throughput: one character per cycle from the single output register while i_out_ready
// is high; a byte causes 1 to 4 characters, so a byte is taken every cycle until the
// 4-entry job queue fills, and on a long message every three bytes cost four characters.
// Reset: synchronous active-low i_rst_n clears phase, leftover bits, queue and output valid.
`default_nettype none

module base64_stream_encoder_unit
    import b64se_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // input byte channel
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    // output character channel
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    // Front: classifies each byte by group phase into a job of characters.
    // Queue: holds jobs so the front keeps taking bytes while the back drains.
    // Back:  emits the characters of the head job, one per output beat.
    logic      push, pop;
    t_job      front_job, head_job;
    t_q_status q_status;

    b64se_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (front_job)
    );

    b64se_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    b64se_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

`ifndef NO_ASSERTIONS
    // end of message only ever falls on the last character of a run
    a_eom_on_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.end_of_message |-> o_out_beat.end_of_run)
        else $error("end_of_message without end_of_run");

    // queue status is never full and empty together
    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // a job is only retired when there is one
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // nothing is presented on the first cycle after reset
    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid straight after reset");
`endif

endmodule

`default_nettype wire
